@@ src/sha512_hash_unit_defines.svh @@
// ---------------------------------------------------------------------------
// sha512_hash_unit_defines.svh
// Assertion macros shared by the hash unit.
// ---------------------------------------------------------------------------
`ifndef SHA512_HASH_UNIT_DEFINES_SVH
`define SHA512_HASH_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define S512H_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sha512 hash unit assertion failed");
// Check that a condition implies another in the next cycle.
`define S512H_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("sha512 hash unit assertion failed");
`else
`define S512H_ASSERT(lbl, prop)
`define S512H_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

@@ src/s512h_pkg.sv @@
// ---------------------------------------------------------------------------
// s512h_pkg
// Types, constants and round functions of the SHA-512 hash unit.
// ---------------------------------------------------------------------------
package s512h_pkg;

    typedef struct packed {
        logic        sched_load;
        logic        var_load;
        logic        var_shift;
        logic        start;
        logic [63:0] sched_word;
        logic [63:0] var_word;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    localparam int unsigned ROUNDS = 80;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0:    init_hash = 64'h6a09e667f3bcc908;
            3'd1:    init_hash = 64'hbb67ae8584caa73b;
            3'd2:    init_hash = 64'h3c6ef372fe94f82b;
            3'd3:    init_hash = 64'ha54ff53a5f1d36f1;
            3'd4:    init_hash = 64'h510e527fade682d1;
            3'd5:    init_hash = 64'h9b05688c2b3e6c1f;
            3'd6:    init_hash = 64'h1f83d9abfb41bd6b;
            default: init_hash = 64'h5be0cd19137e2179;
        endcase
    endfunction

    function automatic logic [63:0] round_const(input logic [6:0] t);
        case (t)
            7'd0:  round_const = 64'h428a2f98d728ae22;
            7'd1:  round_const = 64'h7137449123ef65cd;
            7'd2:  round_const = 64'hb5c0fbcfec4d3b2f;
            7'd3:  round_const = 64'he9b5dba58189dbbc;
            7'd4:  round_const = 64'h3956c25bf348b538;
            7'd5:  round_const = 64'h59f111f1b605d019;
            7'd6:  round_const = 64'h923f82a4af194f9b;
            7'd7:  round_const = 64'hab1c5ed5da6d8118;
            7'd8:  round_const = 64'hd807aa98a3030242;
            7'd9:  round_const = 64'h12835b0145706fbe;
            7'd10: round_const = 64'h243185be4ee4b28c;
            7'd11: round_const = 64'h550c7dc3d5ffb4e2;
            7'd12: round_const = 64'h72be5d74f27b896f;
            7'd13: round_const = 64'h80deb1fe3b1696b1;
            7'd14: round_const = 64'h9bdc06a725c71235;
            7'd15: round_const = 64'hc19bf174cf692694;
            7'd16: round_const = 64'he49b69c19ef14ad2;
            7'd17: round_const = 64'hefbe4786384f25e3;
            7'd18: round_const = 64'h0fc19dc68b8cd5b5;
            7'd19: round_const = 64'h240ca1cc77ac9c65;
            7'd20: round_const = 64'h2de92c6f592b0275;
            7'd21: round_const = 64'h4a7484aa6ea6e483;
            7'd22: round_const = 64'h5cb0a9dcbd41fbd4;
            7'd23: round_const = 64'h76f988da831153b5;
            7'd24: round_const = 64'h983e5152ee66dfab;
            7'd25: round_const = 64'ha831c66d2db43210;
            7'd26: round_const = 64'hb00327c898fb213f;
            7'd27: round_const = 64'hbf597fc7beef0ee4;
            7'd28: round_const = 64'hc6e00bf33da88fc2;
            7'd29: round_const = 64'hd5a79147930aa725;
            7'd30: round_const = 64'h06ca6351e003826f;
            7'd31: round_const = 64'h142929670a0e6e70;
            7'd32: round_const = 64'h27b70a8546d22ffc;
            7'd33: round_const = 64'h2e1b21385c26c926;
            7'd34: round_const = 64'h4d2c6dfc5ac42aed;
            7'd35: round_const = 64'h53380d139d95b3df;
            7'd36: round_const = 64'h650a73548baf63de;
            7'd37: round_const = 64'h766a0abb3c77b2a8;
            7'd38: round_const = 64'h81c2c92e47edaee6;
            7'd39: round_const = 64'h92722c851482353b;
            7'd40: round_const = 64'ha2bfe8a14cf10364;
            7'd41: round_const = 64'ha81a664bbc423001;
            7'd42: round_const = 64'hc24b8b70d0f89791;
            7'd43: round_const = 64'hc76c51a30654be30;
            7'd44: round_const = 64'hd192e819d6ef5218;
            7'd45: round_const = 64'hd69906245565a910;
            7'd46: round_const = 64'hf40e35855771202a;
            7'd47: round_const = 64'h106aa07032bbd1b8;
            7'd48: round_const = 64'h19a4c116b8d2d0c8;
            7'd49: round_const = 64'h1e376c085141ab53;
            7'd50: round_const = 64'h2748774cdf8eeb99;
            7'd51: round_const = 64'h34b0bcb5e19b48a8;
            7'd52: round_const = 64'h391c0cb3c5c95a63;
            7'd53: round_const = 64'h4ed8aa4ae3418acb;
            7'd54: round_const = 64'h5b9cca4f7763e373;
            7'd55: round_const = 64'h682e6ff3d6b2b8a3;
            7'd56: round_const = 64'h748f82ee5defb2fc;
            7'd57: round_const = 64'h78a5636f43172f60;
            7'd58: round_const = 64'h84c87814a1f0ab72;
            7'd59: round_const = 64'h8cc702081a6439ec;
            7'd60: round_const = 64'h90befffa23631e28;
            7'd61: round_const = 64'ha4506cebde82bde9;
            7'd62: round_const = 64'hbef9a3f7b2c67915;
            7'd63: round_const = 64'hc67178f2e372532b;
            7'd64: round_const = 64'hca273eceea26619c;
            7'd65: round_const = 64'hd186b8c721c0c207;
            7'd66: round_const = 64'heada7dd6cde0eb1e;
            7'd67: round_const = 64'hf57d4f7fee6ed178;
            7'd68: round_const = 64'h06f067aa72176fba;
            7'd69: round_const = 64'h0a637dc5a2c898a6;
            7'd70: round_const = 64'h113f9804bef90dae;
            7'd71: round_const = 64'h1b710b35131c471b;
            7'd72: round_const = 64'h28db77f523047d84;
            7'd73: round_const = 64'h32caab7b40c72493;
            7'd74: round_const = 64'h3c9ebe0a15c9bebc;
            7'd75: round_const = 64'h431d67c49c100d4c;
            7'd76: round_const = 64'h4cc5d4becb3e42b6;
            7'd77: round_const = 64'h597f299cfc657e2a;
            7'd78: round_const = 64'h5fcb6fab3ad6faec;
            7'd79: round_const = 64'h6c44198c4a475817;
            default: round_const = 64'h0;
        endcase
    endfunction

endpackage

@@ src/s512h_ram.sv @@
// ---------------------------------------------------------------------------
// s512h_ram
// Generic simple dual-port RAM with a registered read.
// ---------------------------------------------------------------------------
module s512h_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/s512h_core.sv @@
// ---------------------------------------------------------------------------
// s512h_core
// SHA-512 round engine: schedule window, working variables, round counter.
// ---------------------------------------------------------------------------
module s512h_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  s512h_pkg::core_ctl_t  ctl,
    output s512h_pkg::core_sts_t  sts,
    output logic [63:0]           var_head
);
    import s512h_pkg::*;

    logic [63:0] sched_reg [16];
    logic [63:0] var_reg   [8];
    logic [6:0]  round_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] w_next;
    logic [63:0] t1;
    logic [63:0] t2;

    always_comb
    begin
        w_next = ssig1(sched_reg[14]) + sched_reg[9] + ssig0(sched_reg[1]) + sched_reg[0];
        t1 = var_reg[7] + bsig1(var_reg[4])
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + round_const(round_reg) + sched_reg[0];
        t2 = bsig0(var_reg[0])
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end
            else if (run_reg)
            begin
                round_reg <= round_reg + 7'd1;
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload datapath: window and variables shift, no reset needed.
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= w_next;
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
        else
        begin
            if (ctl.sched_load)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    sched_reg[i] <= sched_reg[i+1];
                end
                sched_reg[15] <= ctl.sched_word;
            end
            if (ctl.var_load || ctl.var_shift)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    var_reg[i] <= var_reg[i+1];
                end
                var_reg[7] <= ctl.var_load ? ctl.var_word : 64'h0;
            end
        end
    end

    assign var_head = var_reg[0];
    assign sts.busy = run_reg;
    assign sts.done = done_reg;
endmodule

@@ src/sha512_hash_unit.sv @@
// ---------------------------------------------------------------------------
// sha512_hash_unit
// Streaming SHA-512 hash of a message given as 64-bit big-endian words.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one request carries eight message
// bytes, first byte in bits 63..56. byte_count counts valid leading bytes
// and matters only when last is high (0..8, larger values act as 8).
// Output channel (out_valid / out_stall): eight requests per message, the
// digest words from most significant (digest_pos 0) to least, with
// last_word high on the eighth.
// A word that does not fill a block goes into the block buffer and the unit
// stays ready for the next one. The sixteenth word of a block starts the
// compression: the block buffer and chain hash memories are read into the
// one-round-per-cycle engine, which then runs all rounds, and the chain hash
// memory is updated by read-modify-write with the working variables.
// A last request adds padding writes, one or two compressions, then the
// digest words, each held on the output until the receiver takes it.
// Reset: the chain hash returns to the initial values through valid bits,
// length and word position clear; the unit is ready right out of reset.
// A stall on the output holds the current digest word and the sequence; no
// new message is taken until the last digest word has left.
// ---------------------------------------------------------------------------
`include "sha512_hash_unit_defines.svh"

module sha512_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  digest_pos,
    output logic        last_word
);
    import s512h_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PUSH, S_CLOAD, S_CRUN, S_CUPD, S_ORD, S_OLD, S_OWAIT
    } state_t;

    typedef enum logic [2:0] {
        K_FIRST, K_MARK, K_ZERO, K_LENHI, K_LEN, K_DONE
    } pad_t;

    state_t      state_reg;
    pad_t        kind_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  pos_reg;
    logic [63:0] bitlen_reg;
    logic        pad_act_reg;
    logic        full8_reg;
    logic [63:0] pend_reg;
    logic [7:0]  hval_reg;
    logic [2:0]  haddr_q_reg;
    logic        hsel_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;

    logic        in_acc;
    logic [3:0]  cnt_clamp;
    logic [5:0]  sh;
    logic [63:0] pad_word;

    logic        buf_we;
    logic [63:0] buf_wdata;
    logic [63:0] buf_rdata;
    logic        hash_we;
    logic [2:0]  hash_waddr;
    logic [63:0] hash_wdata;
    logic [2:0]  hash_raddr;
    logic [63:0] hash_rdata;
    logic [63:0] hash_rd;
    logic        push_write;
    logic [63:0] push_word;

    core_ctl_t   core_ctl;
    core_sts_t   core_sts;
    logic [63:0] var_head;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Clamp the byte count and build the masked word with its 0x80 marker.
    assign cnt_clamp = (byte_count > 4'd8) ? 4'd8 : byte_count;
    assign sh        = {cnt_clamp[2:0], 3'b000};
    assign pad_word  = (data & ~({64{1'b1}} >> sh)) | (64'h8000_0000_0000_0000 >> sh);

    // Chain hash entry not yet written since reset or a digest reads as IV.
    assign hash_rd = hsel_reg ? hash_rdata : init_hash(haddr_q_reg);

    always_comb
    begin
        push_write = 1'b0;
        push_word  = 64'h0;
        case (kind_reg)
            K_FIRST:
            begin
                push_write = 1'b1;
                push_word  = pend_reg;
            end
            K_MARK:
            begin
                push_write = 1'b1;
                push_word  = 64'h8000_0000_0000_0000;
            end
            K_ZERO:  push_write = (pos_reg != 4'd14);
            K_LENHI: push_write = 1'b1;
            K_LEN:
            begin
                push_write = 1'b1;
                push_word  = bitlen_reg;
            end
            default: push_write = 1'b0;
        endcase
    end

    always_comb
    begin
        buf_we    = 1'b0;
        buf_wdata = data;
        if (state_reg == S_IDLE)
        begin
            buf_we = in_acc && !last;
        end
        else if (state_reg == S_PUSH)
        begin
            buf_we    = push_write;
            buf_wdata = push_word;
        end
    end

    always_comb
    begin
        hash_raddr = cnt_reg[2:0];
        hash_we    = (state_reg == S_CUPD) && (cnt_reg != 5'd0);
        hash_waddr = 3'(cnt_reg - 5'd1);
        hash_wdata = hash_rd + var_head;

        core_ctl.sched_load = (state_reg == S_CLOAD) && (cnt_reg != 5'd0);
        core_ctl.var_load   = (state_reg == S_CLOAD) && (cnt_reg != 5'd0) && (cnt_reg <= 5'd8);
        core_ctl.var_shift  = hash_we;
        core_ctl.start      = (state_reg == S_CLOAD) && (cnt_reg == 5'd16);
        core_ctl.sched_word = buf_rdata;
        core_ctl.var_word   = hash_rd;
    end

    s512h_ram #(.WIDTH(64), .DEPTH(16)) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (pos_reg),
        .wdata (buf_wdata),
        .raddr (cnt_reg[3:0]),
        .rdata (buf_rdata)
    );

    s512h_ram #(.WIDTH(64), .DEPTH(8)) u_hash (
        .clk   (clk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .raddr (hash_raddr),
        .rdata (hash_rdata)
    );

    s512h_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (core_ctl),
        .sts      (core_sts),
        .var_head (var_head)
    );

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc && last)
        begin
            pend_reg <= (cnt_clamp == 4'd8) ? data : pad_word;
        end
        if (state_reg == S_OLD)
        begin
            out_data_reg <= hash_rd;
            out_idx_reg  <= cnt_reg[2:0];
            out_last_reg <= (cnt_reg[2:0] == 3'd7);
        end
        haddr_q_reg <= hash_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_DONE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            bitlen_reg    <= '0;
            pad_act_reg   <= 1'b0;
            full8_reg     <= 1'b0;
            hval_reg      <= '0;
            hsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hsel_reg <= hval_reg[hash_raddr];
            if (hash_we)
            begin
                hval_reg[hash_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (last)
                        begin
                            bitlen_reg  <= bitlen_reg + 64'({cnt_clamp, 3'b000});
                            full8_reg   <= (cnt_clamp == 4'd8);
                            kind_reg    <= K_FIRST;
                            pad_act_reg <= 1'b1;
                            state_reg   <= S_PUSH;
                        end
                        else
                        begin
                            bitlen_reg <= bitlen_reg + 64'd64;
                            pos_reg    <= pos_reg + 4'd1;
                            if (pos_reg == 4'd15)
                            begin
                                cnt_reg   <= '0;
                                state_reg <= S_CLOAD;
                            end
                        end
                    end
                end
                S_PUSH:
                begin
                    case (kind_reg)
                        K_FIRST: kind_reg <= full8_reg ? K_MARK : K_ZERO;
                        K_MARK:  kind_reg <= K_ZERO;
                        K_ZERO:
                        begin
                            if (pos_reg == 4'd14)
                            begin
                                kind_reg <= K_LENHI;
                            end
                        end
                        K_LENHI: kind_reg <= K_LEN;
                        default: kind_reg <= K_DONE;
                    endcase
                    if (push_write)
                    begin
                        pos_reg <= pos_reg + 4'd1;
                        if (pos_reg == 4'd15)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_CLOAD;
                        end
                    end
                end
                S_CLOAD:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16)
                    begin
                        state_reg <= S_CRUN;
                    end
                end
                S_CRUN:
                begin
                    if (core_sts.done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_CUPD;
                    end
                end
                S_CUPD:
                begin
                    if (cnt_reg == 5'd8)
                    begin
                        cnt_reg <= '0;
                        if (!pad_act_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (kind_reg == K_DONE)
                        begin
                            state_reg <= S_ORD;
                        end
                        else
                        begin
                            state_reg <= S_PUSH;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_OLD;
                end
                S_OLD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (cnt_reg == 5'd7)
                        begin
                            // Drop the chain hash back to IV and clear the message.
                            hval_reg    <= '0;
                            bitlen_reg  <= '0;
                            pos_reg     <= '0;
                            pad_act_reg <= 1'b0;
                            cnt_reg     <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 5'd1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_data_reg;
    assign digest_pos  = out_idx_reg;
    assign last_word   = out_last_reg;

    `S512H_ASSERT(a_no_in_while_out, in_acc |-> !out_valid_reg)
    `S512H_ASSERT(a_start_idle_core, core_ctl.start |-> !core_sts.busy)
    `S512H_ASSERT(a_done_in_run, core_sts.done |-> (state_reg == S_CRUN))
    `S512H_ASSERT_NEXT(a_last_clears, out_valid_reg && !out_stall && out_last_reg,
                       (hval_reg == 8'h00) && (pos_reg == 4'd0))
endmodule
